### src/xml_entity_unescape_assert.svh
// Assertion helpers shared by xeu_cmd_fifo and xeu_back.
`ifndef XML_ENTITY_UNESCAPE_ASSERT_SVH
`define XML_ENTITY_UNESCAPE_ASSERT_SVH

// same-cycle implication
`define XEU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xeu assertion failed");

// next-cycle implication
`define XEU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xeu assertion failed");

`endif

### src/xeu_pkg.sv
package xeu_pkg;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = CMD_PTR_W + 1;

	localparam logic [15:0] CAP_RESET = 16'd256;

	// pending prefix codes
	localparam logic [3:0] P_NONE = 4'd0;
	localparam logic [3:0] P_AMP  = 4'd1;
	localparam logic [3:0] P_L    = 4'd2;
	localparam logic [3:0] P_LT   = 4'd3;
	localparam logic [3:0] P_G    = 4'd4;
	localparam logic [3:0] P_GT   = 4'd5;
	localparam logic [3:0] P_A    = 4'd6;
	localparam logic [3:0] P_AM   = 4'd7;
	localparam logic [3:0] P_AMP2 = 4'd8;
	localparam logic [3:0] P_AP   = 4'd9;
	localparam logic [3:0] P_APO  = 4'd10;
	localparam logic [3:0] P_APOS = 4'd11;
	localparam logic [3:0] P_Q    = 4'd12;
	localparam logic [3:0] P_QU   = 4'd13;
	localparam logic [3:0] P_QUO  = 4'd14;
	localparam logic [3:0] P_QUOT = 4'd15;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_LT   = 8'h3c;
	localparam logic [7:0] CH_GT   = 8'h3e;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LG   = 8'h67;
	localparam logic [7:0] CH_LL   = 8'h6c;
	localparam logic [7:0] CH_LM   = 8'h6d;
	localparam logic [7:0] CH_LO   = 8'h6f;
	localparam logic [7:0] CH_LP   = 8'h70;
	localparam logic [7:0] CH_LQ   = 8'h71;
	localparam logic [7:0] CH_LS   = 8'h73;
	localparam logic [7:0] CH_LT_T = 8'h74;
	localparam logic [7:0] CH_LU   = 8'h75;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_CHAR,
		ACT_TERM
	} act_t;

	typedef struct packed {
		logic [3:0] flush;
		act_t       act;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		logic       done;
		logic       ok;
		logic [3:0] nxt;
		logic [7:0] ch;
	} adv_t;

	function automatic adv_t advance(input logic [3:0] s, input logic [7:0] b);
		adv_t r;
		r = '{done: 1'b0, ok: 1'b0, nxt: P_NONE, ch: CH_NUL};
		case (s)
			P_AMP: begin
				r.ok = 1'b1;
				if (b == CH_LL) r.nxt = P_L;
				else if (b == CH_LG) r.nxt = P_G;
				else if (b == CH_LA) r.nxt = P_A;
				else if (b == CH_LQ) r.nxt = P_Q;
				else r.ok = 1'b0;
			end
			P_L:    begin r.ok = (b == CH_LT_T); r.nxt = P_LT; end
			P_LT:   begin r.done = (b == CH_SEMI); r.ch = CH_LT; end
			P_G:    begin r.ok = (b == CH_LT_T); r.nxt = P_GT; end
			P_GT:   begin r.done = (b == CH_SEMI); r.ch = CH_GT; end
			P_A: begin
				r.ok = 1'b1;
				if (b == CH_LM) r.nxt = P_AM;
				else if (b == CH_LP) r.nxt = P_AP;
				else r.ok = 1'b0;
			end
			P_AM:   begin r.ok = (b == CH_LP); r.nxt = P_AMP2; end
			P_AMP2: begin r.done = (b == CH_SEMI); r.ch = CH_AMP; end
			P_AP:   begin r.ok = (b == CH_LO); r.nxt = P_APO; end
			P_APO:  begin r.ok = (b == CH_LS); r.nxt = P_APOS; end
			P_APOS: begin r.done = (b == CH_SEMI); r.ch = CH_APOS; end
			P_Q:    begin r.ok = (b == CH_LU); r.nxt = P_QU; end
			P_QU:   begin r.ok = (b == CH_LO); r.nxt = P_QUO; end
			P_QUO:  begin r.ok = (b == CH_LT_T); r.nxt = P_QUOT; end
			P_QUOT: begin r.done = (b == CH_SEMI); r.ch = CH_QUOT; end
			default: r = '{done: 1'b0, ok: 1'b0, nxt: P_NONE, ch: CH_NUL};
		endcase
		return r;
	endfunction

	function automatic logic [2:0] pend_len(input logic [3:0] s);
		logic [2:0] n;
		case (s)
			P_NONE: n = 3'd0;
			P_AMP: n = 3'd1;
			P_L, P_G, P_A, P_Q: n = 3'd2;
			P_LT, P_GT, P_AM, P_AP, P_QU: n = 3'd3;
			P_AMP2, P_APO, P_QUO: n = 3'd4;
			P_APOS, P_QUOT: n = 3'd5;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// i-th byte of the text held under prefix code s
	function automatic logic [7:0] pend_char(input logic [3:0] s, input logic [2:0] i);
		logic [4:0][7:0] t;
		logic [7:0] c;
		t = '0;
		t[0] = CH_AMP;
		case (s)
			P_L:    t[1] = CH_LL;
			P_LT:   begin t[1] = CH_LL; t[2] = CH_LT_T; end
			P_G:    t[1] = CH_LG;
			P_GT:   begin t[1] = CH_LG; t[2] = CH_LT_T; end
			P_A:    t[1] = CH_LA;
			P_AM:   begin t[1] = CH_LA; t[2] = CH_LM; end
			P_AMP2: begin t[1] = CH_LA; t[2] = CH_LM; t[3] = CH_LP; end
			P_AP:   begin t[1] = CH_LA; t[2] = CH_LP; end
			P_APO:  begin t[1] = CH_LA; t[2] = CH_LP; t[3] = CH_LO; end
			P_APOS: begin t[1] = CH_LA; t[2] = CH_LP; t[3] = CH_LO; t[4] = CH_LS; end
			P_Q:    t[1] = CH_LQ;
			P_QU:   begin t[1] = CH_LQ; t[2] = CH_LU; end
			P_QUO:  begin t[1] = CH_LQ; t[2] = CH_LU; t[3] = CH_LO; end
			P_QUOT: begin t[1] = CH_LQ; t[2] = CH_LU; t[3] = CH_LO; t[4] = CH_LT_T; end
			default: t[1] = CH_NUL;
		endcase
		case (i)
			3'd0: c = t[0];
			3'd1: c = t[1];
			3'd2: c = t[2];
			3'd3: c = t[3];
			3'd4: c = t[4];
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

### src/xml_entity_unescape.sv
// Commands from the front end are written to a registered command queue, and the back
// end registers each result that it emits. Throughput: one byte per cycle while the
// queue is not full; a command that flushes a failed prefix sends each held byte out in
// turn, then its own character if it has one; the 4-entry command queue absorbs the burst.
// Reset (arst_n low, asynchronous): capacity 256, no pending prefix, count zero,
// command queue and result register empty.
module xml_entity_unescape import xeu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  src_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        end_of_string,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic q_full;
	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_pop;
	cmd_t cmd_head;
	logic cmd_valid;

	assign cfg_ready = 1'b1;

	xeu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.src_byte (src_byte),
		.q_full   (q_full),
		.full     (full),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	xeu_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (q_full),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.valid   (cmd_valid)
	);

	xeu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.cmd_valid     (cmd_valid),
		.head          (cmd_head),
		.cmd_pop       (cmd_pop),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.end_of_string (end_of_string)
	);

endmodule

### src/xeu_front.sv
module xeu_front import xeu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] src_byte,
	input  logic       q_full,
	output logic       full,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic [3:0] prefix_q;
	logic [3:0] prefix_d;
	logic       accept;
	adv_t       adv;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign adv    = advance(prefix_q, src_byte);

	always_comb begin
		prefix_d = prefix_q;
		cmd_push = 1'b0;
		cmd      = '{flush: P_NONE, act: ACT_NONE, ch: src_byte};
		if (accept) begin
			if (src_byte == CH_NUL) begin
				cmd_push = 1'b1;
				cmd.flush = prefix_q;
				cmd.act   = ACT_TERM;
				prefix_d  = P_NONE;
			end else if (prefix_q != P_NONE && adv.done) begin
				cmd_push = 1'b1;
				cmd.act  = ACT_CHAR;
				cmd.ch   = adv.ch;
				prefix_d = P_NONE;
			end else if (prefix_q != P_NONE && adv.ok) begin
				prefix_d = adv.nxt;
			end else begin
				// failed prefix (or none): held bytes go out, byte handled fresh
				cmd.flush = prefix_q;
				if (src_byte == CH_AMP) begin
					prefix_d = P_AMP;
					cmd_push = (prefix_q != P_NONE);
				end else begin
					prefix_d = P_NONE;
					cmd.act  = ACT_CHAR;
					cmd_push = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= P_NONE;
		end else begin
			prefix_q <= prefix_d;
		end
	end

endmodule

### src/xeu_cmd_fifo.sv
`include "xml_entity_unescape_assert.svh"

module xeu_cmd_fifo import xeu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic valid
);

	cmd_t                 mem_q [CMD_DEPTH];
	logic [CMD_PTR_W-1:0] wr_ptr_q;
	logic [CMD_PTR_W-1:0] rd_ptr_q;
	logic [CMD_CNT_W-1:0] count_q;

	assign full    = (count_q == CMD_CNT_W'(CMD_DEPTH));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`XEU_ASSERT_IMPL(a_no_overflow, full, !wr_en)
	`XEU_ASSERT_IMPL(a_no_underflow, !valid, !rd_en)
	`XEU_ASSERT_NEXT(a_ptr_gap, 1'b1, CMD_PTR_W'(wr_ptr_q - rd_ptr_q) == CMD_PTR_W'(count_q))

endmodule

### src/xeu_back.sv
`include "xml_entity_unescape_assert.svh"

module xeu_back import xeu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        cmd_valid,
	input  cmd_t        head,
	output logic        cmd_pop,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  out_byte,
	output logic        end_of_string
);

	logic [15:0] cap_q;
	logic [15:0] count_q;
	logic [2:0]  idx_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_eos_q;

	logic [15:0] limit;
	logic [2:0]  flen;
	logic        last_step;
	logic        slot_free;
	logic        step_en;
	logic        in_flush;
	logic        is_term;
	logic        emit;
	logic [7:0]  ch;

	assign limit     = (cap_q == '0) ? '0 : cap_q - 16'd1;
	assign flen      = pend_len(head.flush);
	assign last_step = (head.act != ACT_NONE) ? (idx_q == flen) : (idx_q == flen - 3'd1);
	assign slot_free = !out_valid_q || pop;
	assign step_en   = cmd_valid && slot_free;
	assign in_flush  = (idx_q < flen);
	assign ch        = in_flush ? pend_char(head.flush, idx_q) : head.ch;
	assign is_term   = !in_flush && (head.act == ACT_TERM);
	// characters after the first cap - 1 are dropped; the terminator always goes out
	assign emit      = step_en && (is_term || (count_q < limit));
	assign cmd_pop   = step_en && last_step;

	assign empty         = !out_valid_q;
	assign out_byte      = out_byte_q;
	assign end_of_string = out_eos_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= is_term ? CH_NUL : ch;
			out_eos_q  <= is_term;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_data;
			if (slot_free) out_valid_q <= emit;
			if (step_en) begin
				idx_q <= last_step ? 3'd0 : idx_q + 3'd1;
				if (is_term) count_q <= '0;
				else if (emit) count_q <= count_q + 16'd1;
			end
		end
	end

	`XEU_ASSERT_IMPL(a_idle_idx, !cmd_valid, idx_q == 3'd0)
	`XEU_ASSERT_IMPL(a_idx_range, cmd_valid, idx_q <= flen)
	`XEU_ASSERT_NEXT(a_term_clears, step_en && is_term, count_q == '0 && out_eos_q)

endmodule

### tb/sv/xml_entity_unescape_test.sv
`timescale 1ns / 100ps

module xml_entity_unescape_test;
	import xeu_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 80;

	typedef struct packed {
		logic [7:0] ch;
		logic       eos;
	} dec_char_t;

	typedef struct {
		logic [7:0] b;
		bit         typed;
		logic [7:0] want_b;
		bit         want_e;
	} dir_row_t;

	typedef struct {
		logic [15:0] cap;
		bit          rand_cap;
		int          tx_pct;
		int          rx_pct;
		int          items;
		bit          hold_rx;
		bit          drain_mid;
	} phase_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  src_byte;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  out_byte;
	logic        end_of_string;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	// decoder model state
	logic [15:0] dest_cap = CAP_RESET;
	logic [3:0]  cur_prefix = P_NONE;
	logic [15:0] char_count = '0;
	dec_char_t   expected_chars [$];

	logic [7:0]  src_bytes [$];
	int          mismatches = 0;
	int          quiet_cycles = 0;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	bit          hold_req = 1'b0;
	int          hold_left = 0;
	dec_char_t   head;

	// indexed by prefix code
	string pfx_text [16] = '{"", "&", "&l", "&lt", "&g", "&gt", "&a", "&am", "&amp",
		"&ap", "&apo", "&apos", "&q", "&qu", "&quo", "&quot"};
	string ent_names [5] = '{"&lt;", "&gt;", "&amp;", "&quot;", "&apos;"};
	string entity_letters = "lgtampqsou;&";

	dir_row_t dir_rows [25] = '{
		'{CH_NUL,  1'b1, CH_NUL,  1'b1},
		'{8'hff,   1'b1, 8'hff,   1'b0},
		'{8'h01,   1'b1, 8'h01,   1'b0},
		'{CH_AMP,  1'b0, CH_NUL,  1'b0},
		'{CH_LL,   1'b0, CH_NUL,  1'b0},
		'{CH_LT_T, 1'b0, CH_NUL,  1'b0},
		'{CH_SEMI, 1'b1, CH_LT,   1'b0},
		'{CH_AMP,  1'b0, CH_NUL,  1'b0},
		'{CH_LQ,   1'b0, CH_NUL,  1'b0},
		'{CH_LU,   1'b0, CH_NUL,  1'b0},
		'{CH_LO,   1'b0, CH_NUL,  1'b0},
		'{CH_LT_T, 1'b0, CH_NUL,  1'b0},
		'{CH_SEMI, 1'b1, CH_QUOT, 1'b0},
		// broken apos, then a stray byte
		'{CH_AMP,  1'b0, CH_NUL,  1'b0},
		'{CH_LA,   1'b0, CH_NUL,  1'b0},
		'{CH_LP,   1'b0, CH_NUL,  1'b0},
		'{8'h78,   1'b0, CH_NUL,  1'b0},
		// second amp restarts the prefix, end of string flushes it
		'{CH_AMP,  1'b0, CH_NUL,  1'b0},
		'{CH_AMP,  1'b0, CH_NUL,  1'b0},
		'{CH_NUL,  1'b0, CH_NUL,  1'b0},
		'{CH_AMP,  1'b0, CH_NUL,  1'b0},
		'{CH_LA,   1'b0, CH_NUL,  1'b0},
		'{CH_LM,   1'b0, CH_NUL,  1'b0},
		'{CH_LP,   1'b0, CH_NUL,  1'b0},
		'{CH_NUL,  1'b0, CH_NUL,  1'b0}
	};

	phase_t phases [7] = '{
		'{16'd200,   1'b0, 0,  0,  80, 1'b0, 1'b0},
		'{16'd0,     1'b0, 74, 0,  40, 1'b0, 1'b0},
		'{16'd1,     1'b0, 0,  74, 40, 1'b0, 1'b0},
		'{16'hffff,  1'b0, 31, 31, 80, 1'b0, 1'b0},
		'{16'd5,     1'b0, 0,  0,  60, 1'b1, 1'b0},
		'{16'd2,     1'b1, 74, 0,  60, 1'b0, 1'b1},
		'{16'd3,     1'b0, 0,  74, 40, 1'b0, 1'b0}
	};

	xml_entity_unescape dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.src_byte     (src_byte),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.end_of_string(end_of_string),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] entity_char(input logic [3:0] p);
		case (p)
			P_LT:    return CH_LT;
			P_GT:    return CH_GT;
			P_AMP2:  return CH_AMP;
			P_APOS:  return CH_APOS;
			P_QUOT:  return CH_QUOT;
			default: return CH_NUL;
		endcase
	endfunction

	task automatic deliver(input logic [7:0] ch, input bit record);
		logic [15:0] limit;
		limit = (dest_cap == 16'd0) ? 16'd0 : dest_cap - 16'd1;
		if (char_count < limit) begin
			if (record)
				expected_chars.push_back('{ch: ch, eos: 1'b0});
			char_count = char_count + 16'd1;
		end
	endtask

	task automatic flush_prefix(input bit record);
		int i;
		for (i = 0; i < pfx_text[cur_prefix].len(); i++)
			deliver(pfx_text[cur_prefix].getc(i), record);
		cur_prefix = P_NONE;
	endtask

	task automatic decode_byte(input logic [7:0] b, input bit record);
		string cand;
		int k;
		bit found;
		logic [3:0] nxt;
		found = 1'b0;
		nxt = P_NONE;
		if (b == CH_NUL) begin
			flush_prefix(record);
			if (record)
				expected_chars.push_back('{ch: CH_NUL, eos: 1'b1});
			char_count = '0;
			return;
		end
		if (cur_prefix != P_NONE) begin
			if (b == CH_SEMI && entity_char(cur_prefix) != CH_NUL) begin
				deliver(entity_char(cur_prefix), record);
				cur_prefix = P_NONE;
				return;
			end
			cand = {pfx_text[cur_prefix], "?"};
			cand.putc(cand.len() - 1, b);
			for (k = 1; k < 16; k++)
				if (pfx_text[k] == cand) begin
					found = 1'b1;
					nxt = 4'(k);
				end
			if (found) begin
				cur_prefix = nxt;
				return;
			end
			flush_prefix(record);
		end
		if (b == CH_AMP)
			cur_prefix = P_AMP;
		else
			deliver(b, record);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_byte(input logic [7:0] b, input bit typed, input logic [7:0] want_b,
			input bit want_e);
		push <= 1'b1;
		src_byte <= b;
		do @(posedge clk); while (full);
		decode_byte(b, !typed);
		if (typed)
			expected_chars.push_back('{ch: want_b, eos: want_e});
		@(negedge clk);
	endtask

	task automatic drain(input int extra);
		push <= 1'b0;
		@(negedge clk);
		while (expected_chars.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_cap(input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		dest_cap = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed entities and text, some broken prefixes, raw bytes and end-of-string bytes
	task automatic queue_chunk();
		int r, k, n;
		string nm;
		r = $urandom_range(99);
		if (r < 40) begin
			if ($urandom_range(1))
				src_bytes.push_back(entity_letters.getc($urandom_range(entity_letters.len() - 1)));
			else
				src_bytes.push_back(8'($urandom_range(8'h7e, 8'h20)));
		end else if (r < 82) begin
			nm = ent_names[$urandom_range(4)];
			n = (r < 70) ? nm.len() : $urandom_range(nm.len() - 1, 1);
			for (k = 0; k < n; k++)
				src_bytes.push_back(nm.getc(k));
			if (r >= 70)
				src_bytes.push_back(8'($urandom_range(255, 1)));
		end else if (r < 90) begin
			src_bytes.push_back(8'($urandom_range(255, 1)));
		end else begin
			src_bytes.push_back(CH_NUL);
		end
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_chars.size() == 0) begin
				report_mismatch("beat with nothing expected", {end_of_string, out_byte}, 0);
			end else begin
				head = expected_chars.pop_front();
				if (out_byte !== head.ch)
					report_mismatch("out_byte", out_byte, head.ch);
				if (end_of_string !== head.eos)
					report_mismatch("end_of_string", end_of_string, head.eos);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		phase_t ph;
		logic [7:0] b;
		logic [15:0] cap;
		int p, sent, i;
		arst_n = 1'b0;
		push = 1'b0;
		src_byte = CH_NUL;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < 25; i++)
			send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want_b, dir_rows[i].want_e);

		for (p = 0; p < 7; p++) begin
			ph = phases[p];
			// dropped characters can still sit in the command queue after the last beat
			drain(30);
			cap = ph.rand_cap ? 16'($urandom_range(20, 2)) : ph.cap;
			write_cap(cap);
			tx_idle_pct = ph.tx_pct;
			rx_stall_pct = ph.rx_pct;
			sent = 0;
			while (sent < ph.items) begin
				if (src_bytes.size() == 0)
					queue_chunk();
				b = src_bytes.pop_front();
				while ($urandom_range(99) < tx_idle_pct) begin
					push <= 1'b0;
					@(negedge clk);
				end
				send_byte(b, 1'b0, CH_NUL, 1'b0);
				sent++;
				// long receiver hold while input keeps coming: queue fills, full rises
				if (ph.hold_rx && sent == 15)
					hold_req = 1'b1;
				if (ph.drain_mid && sent == ph.items / 2)
					drain(0);
			end
		end

		drain(20);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/xeu_pkg.sv
src/xeu_front.sv
src/xeu_cmd_fifo.sv
src/xeu_back.sv
src/xml_entity_unescape.sv
tb/sv/xml_entity_unescape_test.sv
